### rtl/core/ndwg_pkg.sv
// Shared types and codes for the ND-range work-group dispatcher.
// Used by ndwg_enum and ndrange_work_group_dispatcher_top; no dependencies.
package ndwg_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_GLOBAL_X = 3'd0;
    localparam logic [2:0] REG_GLOBAL_Y = 3'd1;
    localparam logic [2:0] REG_GLOBAL_Z = 3'd2;
    localparam logic [2:0] REG_LOCAL_X  = 3'd3;
    localparam logic [2:0] REG_LOCAL_Y  = 3'd4;
    localparam logic [2:0] REG_LOCAL_Z  = 3'd5;
    localparam logic [2:0] REG_UNIFORM  = 3'd6;
    localparam logic [2:0] REG_QUICK    = 3'd7;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_COUNT,
        ST_ISSUE
    } t_state;

    // Controls from the sequencer to the enumerator
    typedef struct packed {
        logic prep;     // count phase: apply restart, load counts if needed
        logic restart;  // request asked to start over
        logic step;     // issue phase: advance the enumeration
    } t_enum_ctl;

endpackage

### rtl/core/ndrange_work_group_dispatcher_top.sv
// With sizes unchanged a request goes from idle through the count and issue states into the
// result register; after a size write the next request first runs three divisions on the
// shared divider, one per dimension.
// Requests are taken one at a time, only in idle; the issue state holds while the result waits.
// Reset: synchronous active-low; sizes return to 1, flags to 0, enumeration restarts.
// Top level; depends on ndwg_pkg, ndwg_div and ndwg_enum.
module ndrange_work_group_dispatcher_top
    import ndwg_pkg::*;
#(
    parameter int GRID_WIDTH  = 32,
    parameter int LOCAL_WIDTH = 16,
    localparam int CFG_W   = (GRID_WIDTH > LOCAL_WIDTH) ? GRID_WIDTH : LOCAL_WIDTH,
    localparam int PAY_W   = 3 * GRID_WIDTH + 3 * LOCAL_WIDTH,
    localparam int TDATA_W = ((PAY_W + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // Request stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [0] restart, rest zero
    // Result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // group_x, group_y, group_z,
                                               // extent_x, extent_y, extent_z, pad
    output logic               m_axis_tuser    // done_res
);

    // Configuration registers
    logic [GRID_WIDTH-1:0]  r_glb [3];
    logic [LOCAL_WIDTH-1:0] r_loc [3];
    logic                   r_uniform;
    logic                   r_quick;

    // Sequencer
    t_state                 r_state, n_state;
    logic [1:0]             r_dim;
    logic                   r_div_ok;
    logic                   r_restart;

    // Division results per dimension
    logic [GRID_WIDTH-1:0]  r_quo [3];
    logic [LOCAL_WIDTH-1:0] r_rem [3];

    // Result register
    logic                   r_m_valid;
    logic [TDATA_W-1:0]     r_m_tdata;
    logic                   r_m_tuser;

    logic                   w_in_beat;
    logic                   w_cfg_beat;
    logic                   w_out_free;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [GRID_WIDTH-1:0]  w_div_quo;
    logic [LOCAL_WIDTH-1:0] w_div_rem;
    logic [LOCAL_WIDTH-1:0] w_leff [3];
    logic [2:0]             w_rem_nz;
    t_enum_ctl              w_ctl;
    logic [GRID_WIDTH-1:0]  w_group [3];
    logic                   w_issue;
    logic [LOCAL_WIDTH-1:0] w_ext [3];
    logic                   w_load_out;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_beat  = i_cfg_valid && o_cfg_ready;
    assign w_in_beat   = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_m_valid || m_axis_tready;

    // Effective local size (zero acts as one), remainder flags, extents
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            w_leff[d]   = (r_loc[d] == '0) ? LOCAL_WIDTH'(1) : r_loc[d];
            w_rem_nz[d] = (r_rem[d] != '0);
            w_ext[d]    = (w_group[d] >= r_quo[d]) ? r_rem[d] : w_leff[d];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < 3; d++) begin
                r_glb[d] <= GRID_WIDTH'(1);
                r_loc[d] <= LOCAL_WIDTH'(1);
            end
            r_uniform <= 1'b0;
            r_quick   <= 1'b0;
        end else if (w_cfg_beat) begin
            unique case (i_cfg_index)
                REG_GLOBAL_X: r_glb[0]  <= i_cfg_data[GRID_WIDTH-1:0];
                REG_GLOBAL_Y: r_glb[1]  <= i_cfg_data[GRID_WIDTH-1:0];
                REG_GLOBAL_Z: r_glb[2]  <= i_cfg_data[GRID_WIDTH-1:0];
                REG_LOCAL_X:  r_loc[0]  <= i_cfg_data[LOCAL_WIDTH-1:0];
                REG_LOCAL_Y:  r_loc[1]  <= i_cfg_data[LOCAL_WIDTH-1:0];
                REG_LOCAL_Z:  r_loc[2]  <= i_cfg_data[LOCAL_WIDTH-1:0];
                REG_UNIFORM:  r_uniform <= i_cfg_data[0];
                REG_QUICK:    r_quick   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    n_state = r_div_ok ? ST_COUNT : ST_DIV_GO;
                end
            end
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_dim == 2'd2) ? ST_COUNT : ST_DIV_GO;
                end
            end
            ST_COUNT:    n_state = ST_ISSUE;
            ST_ISSUE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_ctl         = '0;
        w_load_out    = 1'b0;
        w_ctl.restart = r_restart;
        unique case (r_state)
            ST_IDLE:     s_axis_tready = 1'b1;
            ST_DIV_GO:   w_div_start   = 1'b1;
            ST_DIV_WAIT: ;
            ST_COUNT:    w_ctl.prep    = 1'b1;
            ST_ISSUE: begin
                w_ctl.step = w_out_free;
                w_load_out = w_out_free;
            end
            default: ;
        endcase
    end

    // Sequencer registers and division bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_dim    <= 2'd0;
            r_div_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_beat) begin
                r_dim <= 2'd0;
            end else if (r_state == ST_DIV_WAIT && w_div_done) begin
                r_dim <= r_dim + 2'd1;
                if (r_dim == 2'd2) begin
                    r_div_ok <= 1'b1;
                end
            end
            // any size write makes the stored quotients stale
            if (w_cfg_beat && i_cfg_index <= REG_LOCAL_Z) begin
                r_div_ok <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_restart <= s_axis_tdata[0];
        end
        if (r_state == ST_DIV_WAIT && w_div_done) begin
            r_quo[r_dim] <= w_div_quo;
            r_rem[r_dim] <= w_div_rem;
        end
    end

    ndwg_div #(
        .GRID_WIDTH  (GRID_WIDTH),
        .LOCAL_WIDTH (LOCAL_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_glb[r_dim]),
        .i_divisor  (w_leff[r_dim]),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    ndwg_enum #(
        .GRID_WIDTH (GRID_WIDTH)
    ) u_enum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_quo     (r_quo),
        .i_rem_nz  (w_rem_nz),
        .i_uniform (r_uniform),
        .i_quick   (r_quick),
        .o_group   (w_group),
        .o_issue   (w_issue)
    );

    // Result register; a done beat carries all-zero data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_load_out) begin
            r_m_tdata <= w_issue ?
                TDATA_W'({w_ext[2], w_ext[1], w_ext[0],
                          w_group[2], w_group[1], w_group[0]}) : '0;
            r_m_tuser <= !w_issue;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    // A done beat never carries group data
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("done beat with nonzero data");

    // The divider only finishes while the sequencer waits on it
    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider result outside wait state");

    // A request beat always leaves idle and closes the input
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !s_axis_tready)
        else $error("request accepted while still idle");

    // The result register is loaded only when it is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before taken");

endmodule

### rtl/core/ndwg_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Standalone; instantiated by ndrange_work_group_dispatcher_top.
module ndwg_div #(
    parameter int GRID_WIDTH  = 32,
    parameter int LOCAL_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [GRID_WIDTH-1:0]  i_dividend,
    input  logic [LOCAL_WIDTH-1:0] i_divisor,   // must be nonzero
    output logic                   o_done,
    output logic [GRID_WIDTH-1:0]  o_quo,
    output logic [LOCAL_WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(GRID_WIDTH + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [GRID_WIDTH-1:0]  r_quo, n_quo;
    logic [LOCAL_WIDTH-1:0] r_rem, n_rem;

    logic [LOCAL_WIDTH:0]   w_trial;
    logic [LOCAL_WIDTH:0]   w_diff;
    logic                   w_ge;

    // One restoring step: shift in next dividend bit, try subtract
    always_comb begin
        w_trial = {r_rem, r_quo[GRID_WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_ge    = (w_trial >= {1'b0, i_divisor});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(GRID_WIDTH);
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[GRID_WIDTH-2:0], w_ge};
            n_rem = w_ge ? w_diff[LOCAL_WIDTH-1:0] : w_trial[LOCAL_WIDTH-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### rtl/core/ndwg_enum.sv
// Group enumerator: counts, cursor, quick-mode progress and exhaustion.
// Depends on ndwg_pkg; quotients and remainder-nonzero flags come from the top level.
module ndwg_enum
    import ndwg_pkg::*;
#(
    parameter int GRID_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_enum_ctl             i_ctl,
    input  logic [GRID_WIDTH-1:0] i_quo [3],
    input  logic [2:0]            i_rem_nz,
    input  logic                  i_uniform,
    input  logic                  i_quick,
    output logic [GRID_WIDTH-1:0] o_group [3],
    output logic                  o_issue
);

    logic [GRID_WIDTH-1:0] r_cur [3];
    logic [GRID_WIDTH-1:0] r_cnt [3];
    logic                  r_cnt_ok;
    logic [1:0]            r_qiss;
    logic                  r_exh;

    logic                  w_empty;
    logic                  w_multi;
    logic [2:0]            w_wrap;
    logic                  w_quick_path;
    logic                  w_norm_path;

    // Wrap detection per dimension
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            w_wrap[d] = ({1'b0, r_cur[d]} + 1'b1) >= {1'b0, r_cnt[d]};
        end
        w_empty = (r_cnt[0] == '0) || (r_cnt[1] == '0) || (r_cnt[2] == '0);
        w_multi = (r_cnt[0] != GRID_WIDTH'(1)) || (r_cnt[1] != GRID_WIDTH'(1)) ||
                  (r_cnt[2] != GRID_WIDTH'(1));
        w_quick_path = !w_empty && i_quick;
        w_norm_path  = !w_empty && !i_quick && !r_exh;
    end

    // Group selection for this request
    always_comb begin
        o_issue = 1'b0;
        for (int d = 0; d < 3; d++) begin
            o_group[d] = '0;
        end
        if (w_quick_path) begin
            if (r_qiss == 2'd0) begin
                o_issue = 1'b1;
            end else if (r_qiss == 2'd1 && w_multi) begin
                o_issue = 1'b1;
                for (int d = 0; d < 3; d++) begin
                    o_group[d] = r_cnt[d] - 1'b1;
                end
            end
        end else if (w_norm_path) begin
            o_issue = 1'b1;
            for (int d = 0; d < 3; d++) begin
                o_group[d] = r_cur[d];
            end
        end
    end

    // Enumeration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_ok <= 1'b0;
            r_qiss   <= 2'd0;
            r_exh    <= 1'b0;
            for (int d = 0; d < 3; d++) begin
                r_cur[d] <= '0;
            end
        end else if (i_ctl.prep) begin
            if (i_ctl.restart) begin
                r_qiss <= 2'd0;
                r_exh  <= 1'b0;
                for (int d = 0; d < 3; d++) begin
                    r_cur[d] <= '0;
                end
            end
            r_cnt_ok <= 1'b1;
        end else if (i_ctl.step) begin
            if (w_quick_path) begin
                if (r_qiss == 2'd0) begin
                    r_qiss <= 2'd1;
                end else if (r_qiss == 2'd1) begin
                    r_qiss <= 2'd2;
                end
            end else if (w_norm_path) begin
                // x fastest, then y, then z
                r_cur[0] <= w_wrap[0] ? '0 : r_cur[0] + 1'b1;
                if (w_wrap[0]) begin
                    r_cur[1] <= w_wrap[1] ? '0 : r_cur[1] + 1'b1;
                    if (w_wrap[1]) begin
                        r_cur[2] <= w_wrap[2] ? '0 : r_cur[2] + 1'b1;
                        if (w_wrap[2]) begin
                            r_exh <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Group counts: round up unless uniform groups are required
    always_ff @(posedge i_clk) begin
        if (i_ctl.prep && (i_ctl.restart || !r_cnt_ok)) begin
            for (int d = 0; d < 3; d++) begin
                r_cnt[d] <= i_quo[d] +
                    {{(GRID_WIDTH-1){1'b0}}, (!i_uniform && i_rem_nz[d])};
            end
        end
    end

endmodule

### test/testbench.sv
// Self-checking bench for ndrange_work_group_dispatcher_top: directed and random dispatch
// requests, each result beat checked against an in-bench model of the group enumeration.
// Depends on ndwg_pkg and the dispatcher RTL.
module testbench
    import ndwg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW          = 32;
    localparam int LW          = 16;
    localparam int TDW         = ((3 * GW + 3 * LW + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 250;
    localparam int RANDOM_REQS = 500;

    // One result beat: group coordinates, group extents, done flag
    typedef struct packed {
        logic                 done;
        logic [2:0][LW-1:0]   ext;
        logic [2:0][GW-1:0]   grp;
    } t_group_beat;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [GW-1:0]  i_cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata;   // [0] restart, rest zero
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [TDW-1:0] m_axis_tdata;   // group_x, group_y, group_z, extent_x, extent_y, extent_z
    logic           m_axis_tuser;   // done_res

    // Model copy of the registers
    bit [GW-1:0] grid_global [3];
    bit [LW-1:0] grid_local [3];
    bit          uniform_only;
    bit          quick_only;

    // Model copy of the enumeration state
    bit [GW-1:0] walk_pos [3];
    bit [GW-1:0] group_count [3];
    bit          counts_known;
    bit [1:0]    quick_stage;
    bit          walk_done;

    t_group_beat pending_groups [$];

    int fail_count  = 0;
    int sent_count  = 0;
    int beat_count  = 0;
    int done_count  = 0;
    int phase_count = 0;

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int hold_request = 0;
    int hold_seen    = 0;
    int sink_wait    = 0;

    ndrange_work_group_dispatcher_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Local size of zero counts as one
    function automatic bit [GW-1:0] eff_local(int d);
        return (grid_local[d] == '0) ? GW'(1) : GW'(grid_local[d]);
    endfunction

    // Trailing group gets the remainder, all others the nominal size
    function automatic bit [LW-1:0] group_extent(int d, bit [GW-1:0] g);
        bit [GW-1:0] l;
        l = eff_local(d);
        if (g >= grid_global[d] / l)
            return LW'(grid_global[d] % l);
        return LW'(l);
    endfunction

    // Expected result of one request; advances the model state
    function automatic t_group_beat dispatch_group(bit restart);
        t_group_beat r;
        bit [GW-1:0] g [3];
        bit [GW:0]   q;
        bit          issue;
        bit          empty;
        r     = '0;
        issue = 1'b0;
        g     = '{default: '0};
        if (restart) begin
            walk_pos     = '{default: '0};
            quick_stage  = 2'd0;
            walk_done    = 1'b0;
            counts_known = 1'b0;
        end
        // counts are latched once per enumeration
        if (!counts_known) begin
            for (int d = 0; d < 3; d++) begin
                q = grid_global[d] / eff_local(d);
                if (!uniform_only && (grid_global[d] % eff_local(d)) != 0)
                    q++;
                group_count[d] = q[GW-1:0];
            end
            counts_known = 1'b1;
        end
        empty = (group_count[0] == 0) || (group_count[1] == 0) || (group_count[2] == 0);

        if (!empty && quick_only) begin
            // first group, then last group if distinct
            if (quick_stage == 2'd0) begin
                quick_stage = 2'd1;
                issue       = 1'b1;
            end else if (quick_stage == 2'd1) begin
                quick_stage = 2'd2;
                if (group_count[0] != 1 || group_count[1] != 1 || group_count[2] != 1) begin
                    for (int d = 0; d < 3; d++)
                        g[d] = group_count[d] - 1;
                    issue = 1'b1;
                end
            end
        end else if (!empty && !walk_done) begin
            // x fastest, then y, then z
            g     = walk_pos;
            issue = 1'b1;
            walk_pos[0]++;
            if (walk_pos[0] >= group_count[0]) begin
                walk_pos[0] = '0;
                walk_pos[1]++;
                if (walk_pos[1] >= group_count[1]) begin
                    walk_pos[1] = '0;
                    walk_pos[2]++;
                    if (walk_pos[2] >= group_count[2]) begin
                        walk_pos[2] = '0;
                        walk_done   = 1'b1;
                    end
                end
            end
        end

        if (issue) begin
            for (int d = 0; d < 3; d++) begin
                r.grp[d] = g[d];
                r.ext[d] = group_extent(d, g[d]);
            end
        end else begin
            r.done = 1'b1;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [GW-1:0] want, logic [GW-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Result checker: each accepted beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_group_beat want;
        string       tag;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beat_count++;
            if (m_axis_tuser === 1'b1)
                done_count++;
            if (pending_groups.size() == 0) begin
                $error("unexpected result beat: tdata=%h done=%b", m_axis_tdata, m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_groups[0];
                pending_groups.delete(0);
                for (int d = 0; d < 3; d++) begin
                    tag = (d == 0) ? "x" : (d == 1) ? "y" : "z";
                    check_field({"group_", tag}, want.grp[d], m_axis_tdata[d*GW +: GW]);
                    check_field({"extent_", tag}, GW'(want.ext[d]),
                                GW'(m_axis_tdata[3*GW + d*LW +: LW]));
                end
                check_field("done_res", GW'(want.done), GW'(m_axis_tuser));
            end
        end
    end

    // Result sink: random stall bursts, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            sink_wait = HOLD_CYCLES;
        end
        if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            sink_wait = $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [GW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_GLOBAL_X, REG_GLOBAL_Y, REG_GLOBAL_Z: grid_global[idx] = data;
            REG_LOCAL_X, REG_LOCAL_Y, REG_LOCAL_Z: grid_local[idx - REG_LOCAL_X] = data[LW-1:0];
            REG_UNIFORM: uniform_only = data[0];
            REG_QUICK:   quick_only   = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Local sizes and flags carry random upper bits; only the low bits count
    task automatic set_grid(input bit [GW-1:0] gx, gy, gz, input bit [LW-1:0] lx, ly, lz);
        cfg_write(REG_GLOBAL_X, gx);
        cfg_write(REG_GLOBAL_Y, gy);
        cfg_write(REG_GLOBAL_Z, gz);
        cfg_write(REG_LOCAL_X, {LW'($urandom), lx});
        cfg_write(REG_LOCAL_Y, {LW'($urandom), ly});
        cfg_write(REG_LOCAL_Z, {LW'($urandom), lz});
    endtask

    task automatic set_modes(input bit uniform, input bit quick);
        cfg_write(REG_UNIFORM, {31'($urandom), uniform});
        cfg_write(REG_QUICK, {31'($urandom), quick});
    endtask

    // One request beat; valid stays up across back-to-back beats
    task automatic send_request(input bit restart);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_groups.insert(pending_groups.size(), dispatch_group(restart));
        sent_count++;
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_groups.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Default registers: a single 1x1x1 group, then done, then again after restart
    task automatic test_reset_defaults();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // 5x3x2 grid in 2x2x2 groups: trailing groups get the remainder
    task automatic test_partial_groups();
        wait_drained();
        set_grid(5, 3, 2, 2, 2, 2);
        send_request(1'b1);
        repeat (6) send_request(1'b0);
    endtask

    // Same grid with uniform groups: partial groups dropped
    task automatic test_uniform_groups();
        wait_drained();
        set_modes(1'b1, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    // Quick mode on a full-size grid: first group, far corner, then done
    task automatic test_quick_extremes();
        wait_drained();
        set_grid('1, '1, '1, 1, 2, '1);
        set_modes(1'b0, 1'b1);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    // Switch modes mid-enumeration; each mode resumes its own progress
    task automatic test_mode_switch();
        wait_drained();
        set_grid(3, 2, 1, 1, 1, 1);
        set_modes(1'b0, 1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_drained();
        cfg_write(REG_QUICK, 1);
        send_request(1'b0);
        send_request(1'b0);
        wait_drained();
        cfg_write(REG_QUICK, 0);
        send_request(1'b0);
    endtask

    // Empty grids (zero global, uniform with global below local) and zero local size
    task automatic test_empty_and_zero_local();
        wait_drained();
        set_grid(0, 1, 1, 1, 1, 1);
        send_request(1'b1);
        wait_drained();
        cfg_write(REG_GLOBAL_X, 3);
        cfg_write(REG_LOCAL_X, {LW'($urandom), LW'(0)});
        send_request(1'b1);
        wait_drained();
        cfg_write(REG_UNIFORM, 1);
        cfg_write(REG_GLOBAL_Y, 2);
        cfg_write(REG_LOCAL_Y, 5);
        send_request(1'b1);
    endtask

    // Sink holds off while requests keep coming, so the input backs up
    task automatic test_output_holdoff();
        wait_drained();
        set_grid(4, 3, 2, 1, 1, 1);
        set_modes(1'b0, 1'b0);
        src_idle_on = 1'b0;
        hold_request++;
        send_request(1'b1);
        repeat (9) send_request(1'b0);
        wait_drained();
        src_idle_on = 1'b1;
    endtask

    // Random phases: new modes and in most phases new sizes, then a burst mostly starting with a restart
    task automatic test_random_dispatch();
        int          first;
        int          pick;
        int          burst;
        bit [GW-1:0] gx, gy, gz;
        bit [LW-1:0] lx, ly, lz;
        first = sent_count;
        while (sent_count - first < RANDOM_REQS) begin
            wait_drained();
            phase_count++;
            // quiet tail: no idling on either side
            if (sent_count - first >= RANDOM_REQS - 80) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                gx = $urandom;
                gy = $urandom;
                gz = $urandom;
                lx = $urandom_range(0, 65535);
                ly = $urandom_range(0, 65535);
                lz = $urandom_range(0, 65535);
                set_grid(gx, gy, gz, lx, ly, lz);
            end else if (pick < 14) begin
                gx = (pick == 2) ? 0 : $urandom_range(1, 9);
                gy = $urandom_range(1, 4);
                gz = $urandom_range(1, 3);
                lx = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                ly = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                lz = $urandom_range(1, 2);
                set_grid(gx, gy, gz, lx, ly, lz);
            end
            set_modes($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            burst = $urandom_range(3, 30);
            for (int k = 0; k < burst; k++)
                send_request((k == 0) ? ($urandom_range(0, 3) != 0)
                                      : ($urandom_range(0, 24) == 0));
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        // model state after reset
        grid_global  = '{default: GW'(1)};
        grid_local   = '{default: LW'(1)};
        uniform_only = 1'b0;
        quick_only   = 1'b0;
        walk_pos     = '{default: '0};
        group_count  = '{default: '0};
        counts_known = 1'b0;
        quick_stage  = 2'd0;
        walk_done    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_partial_groups();
        test_uniform_groups();
        test_quick_extremes();
        test_mode_switch();
        test_empty_and_zero_local();
        test_output_holdoff();
        test_random_dispatch();

        wait_drained();
        repeat (110) @(posedge i_clk);
        $display("Dispatched %0d requests (%0d random phases), %0d result beats, %0d done",
                 sent_count, phase_count, beat_count, done_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
